// ===== hw/rtl/prsoi_pkg.sv =====
// Shared types, constants and the arctangent table for the polar range scan block.
`default_nettype none
package prsoi_pkg;
	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_SCALE = 14;
	localparam int STEP_W = 5;
	localparam logic [31:0] BAND_UNITS = 32'd163840;
	localparam logic [7:0] PIXEL_HIT = 8'd255;
	localparam logic [7:0] PIXEL_MISS = 8'd0;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_POINT = 2'd1,
		OP_CELL = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_MIN_HEIGHT = 3'd0,
		REG_MAX_HEIGHT = 3'd1,
		REG_NEAR_BOX_X = 3'd2,
		REG_NEAR_BOX_Y = 3'd3,
		REG_CELL_WIDTH = 3'd4,
		REG_CELL_HEIGHT = 3'd5,
		REG_GRID_OFFSET_X = 3'd6,
		REG_GRID_OFFSET_Y = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] theta;
	} cordic_rsp_t;

	function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'd536870912;
			5'd1: v = 32'd316933406;
			5'd2: v = 32'd167458907;
			5'd3: v = 32'd85004756;
			5'd4: v = 32'd42667331;
			5'd5: v = 32'd21354465;
			5'd6: v = 32'd10679838;
			5'd7: v = 32'd5340245;
			5'd8: v = 32'd2670163;
			5'd9: v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			default: v = 32'd0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/polar_range_scan_occupancy_image_core.sv =====
// Top level: polar nearest-range scan and occupancy cell classifier.
//
// channel  direction  handshake           payload
// in       input      in_valid/in_ready   op, point_x, point_y, point_z, cell_row, cell_col
// out      output     out_valid/out_ready pixel
// cfg      input      cfg_we              cfg_index, cfg_wdata
//
// One item is worked at a time. A point passes through these states before the next word is taken:
// S_INIT starts the CORDIC, S_CORD runs its 20 steps up to the done flag, S_RD reads and S_WR writes.
// A cell adds S_CELL to form its centre and S_OUT to pass the pixel to the output
// register; an off-grid cell goes straight to S_OUT. A frame start sweeps the memory once.
// After reset the same clearing pass runs before the first word is taken.
// A cell stalls only while the output register still holds a word that has not been taken.
`default_nettype none
module polar_range_scan_occupancy_image_core
	import prsoi_pkg::*;
#(
	parameter int BINS = 360,
	parameter int GRID_ROWS = 256,
	parameter int GRID_COLS = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] op,
	input wire logic signed [15:0] point_x,
	input wire logic signed [15:0] point_y,
	input wire logic signed [15:0] point_z,
	input wire logic [7:0] cell_row,
	input wire logic [7:0] cell_col,
	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] pixel
);
	localparam int BIN_W = $clog2(BINS);
	localparam int IDX_W = $clog2(BINS + 1);
	localparam logic [IDX_W-1:0] BINS_C = IDX_W'(BINS);
	localparam logic signed [11:0] HALF_ROWS = 12'(GRID_ROWS / 2);
	localparam logic signed [11:0] HALF_COLS = 12'(GRID_COLS / 2);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_CLR = 8'b0000_0010,
		S_CELL = 8'b0000_0100,
		S_INIT = 8'b0000_1000,
		S_CORD = 8'b0001_0000,
		S_RD = 8'b0010_0000,
		S_WR = 8'b0100_0000,
		S_OUT = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic signed [15:0] min_height_q;
	logic signed [15:0] max_height_q;
	logic [14:0] near_box_x_q;
	logic [14:0] near_box_y_q;
	logic [11:0] cell_width_q;
	logic [11:0] cell_height_q;
	logic signed [15:0] grid_offset_x_q;
	logic signed [15:0] grid_offset_y_q;

	logic is_cell_q;
	logic signed [15:0] x_q;
	logic signed [15:0] y_q;
	logic [7:0] row_q;
	logic [7:0] col_q;
	logic [31:0] xx_q;
	logic [31:0] yy_q;
	logic [31:0] d_q;
	logic [BIN_W-1:0] bin_q;
	logic [BIN_W-1:0] clr_q;
	logic [7:0] pixel_q;
	logic out_valid_q;
	logic [7:0] out_pixel_q;

	logic in_acc;
	logic out_free;
	logic [16:0] ax;
	logic [16:0] ay;
	logic drop;
	logic off_grid;
	logic signed [11:0] row_diff;
	logic signed [11:0] col_diff;
	logic signed [25:0] cx_full;
	logic signed [25:0] cy_full;
	logic signed [15:0] cx_sat;
	logic signed [15:0] cy_sat;
	logic [32+IDX_W-1:0] bin_prod;
	logic [IDX_W-1:0] idx;
	logic [BIN_W-1:0] bin_next;
	cordic_req_t creq;
	cordic_rsp_t crsp;
	logic mem_rd_en;
	logic mem_wr_en;
	logic [BIN_W-1:0] mem_wr_addr;
	logic [32:0] mem_wr_data;
	logic [32:0] mem_rd_data;
	logic bin_ok;
	logic [31:0] bin_r;
	logic [31:0] diff_d;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign pixel = out_pixel_q;
	assign out_free = !out_valid_q || out_ready;

	assign ax = point_x[15] ? 17'(-$signed({point_x[15], point_x})) : {1'b0, point_x};
	assign ay = point_y[15] ? 17'(-$signed({point_y[15], point_y})) : {1'b0, point_y};
	assign drop = (point_z < min_height_q) || (point_z > max_height_q) ||
		((ax < {2'b0, near_box_x_q}) && (ay < {2'b0, near_box_y_q}));
	assign off_grid = ({24'b0, cell_row} >= 32'(GRID_ROWS)) ||
		({24'b0, cell_col} >= 32'(GRID_COLS));

	assign row_diff = HALF_ROWS - $signed({4'b0, row_q});
	assign col_diff = HALF_COLS - $signed({4'b0, col_q});
	assign cx_full = 26'(row_diff * $signed({1'b0, cell_height_q})) + 26'(grid_offset_x_q);
	assign cy_full = 26'(col_diff * $signed({1'b0, cell_width_q})) + 26'(grid_offset_y_q);
	assign cx_sat = (cx_full > 26'sd32767) ? 16'sh7FFF :
		(cx_full < -26'sd32768) ? 16'sh8000 : cx_full[15:0];
	assign cy_sat = (cy_full > 26'sd32767) ? 16'sh7FFF :
		(cy_full < -26'sd32768) ? 16'sh8000 : cy_full[15:0];

	assign bin_prod = (32+IDX_W)'(crsp.theta) * (32+IDX_W)'(BINS_C) + (32+IDX_W)'(32'h8000_0000);
	assign idx = bin_prod[32+IDX_W-1:32];
	assign bin_next = (idx >= BINS_C) ? '0 : idx[BIN_W-1:0];

	assign creq.start = (state_q == S_INIT);
	assign creq.x = x_q;
	assign creq.y = y_q;

	prsoi_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.req(creq),
		.rsp(crsp)
	);

	assign bin_ok = mem_rd_data[32];
	assign bin_r = mem_rd_data[31:0];
	assign diff_d = d_q - bin_r;

	assign mem_rd_en = (state_q == S_RD);
	always_comb begin
		mem_wr_en = 1'b0;
		mem_wr_addr = bin_q;
		mem_wr_data = {1'b1, d_q};
		if (state_q == S_CLR) begin
			mem_wr_en = 1'b1;
			mem_wr_addr = clr_q;
			mem_wr_data = '0;
		end else if (state_q == S_WR && !is_cell_q) begin
			mem_wr_en = !bin_ok || (d_q < bin_r);
		end
	end

	prsoi_bin_mem #(
		.BINS(BINS)
	) u_mem (
		.clk(clk),
		.rd_en(mem_rd_en),
		.rd_addr(bin_q),
		.rd_data(mem_rd_data),
		.wr_en(mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_height_q <= -16'sd154;
			max_height_q <= 16'sd384;
			near_box_x_q <= '0;
			near_box_y_q <= '0;
			cell_width_q <= 12'd45;
			cell_height_q <= 12'd45;
			grid_offset_x_q <= 16'sd2304;
			grid_offset_y_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_HEIGHT: min_height_q <= cfg_wdata;
				REG_MAX_HEIGHT: max_height_q <= cfg_wdata;
				REG_NEAR_BOX_X: near_box_x_q <= cfg_wdata[14:0];
				REG_NEAR_BOX_Y: near_box_y_q <= cfg_wdata[14:0];
				REG_CELL_WIDTH: cell_width_q <= cfg_wdata[11:0];
				REG_CELL_HEIGHT: cell_height_q <= cfg_wdata[11:0];
				REG_GRID_OFFSET_X: grid_offset_x_q <= cfg_wdata;
				REG_GRID_OFFSET_Y: grid_offset_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (op_t'(op))
							OP_CLEAR: begin
								clr_q <= '0;
								state_q <= S_CLR;
							end
							OP_POINT: state_q <= drop ? S_IDLE : S_INIT;
							OP_CELL: state_q <= off_grid ? S_OUT : S_CELL;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BIN_W'(BINS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_CELL: state_q <= S_INIT;
				S_INIT: state_q <= S_CORD;
				S_CORD: begin
					if (crsp.done) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_WR;
				S_WR: state_q <= is_cell_q ? S_OUT : S_IDLE;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			is_cell_q <= (op_t'(op) == OP_CELL);
			x_q <= point_x;
			y_q <= point_y;
			row_q <= cell_row;
			col_q <= cell_col;
			pixel_q <= PIXEL_MISS;
		end
		if (state_q == S_CELL) begin
			x_q <= cx_sat;
			y_q <= cy_sat;
		end
		if (state_q == S_INIT) begin
			xx_q <= 32'(x_q * x_q);
			yy_q <= 32'(y_q * y_q);
		end
		if (state_q == S_CORD) begin
			d_q <= xx_q + yy_q;
			bin_q <= bin_next;
		end
		if (state_q == S_WR) begin
			pixel_q <= (bin_ok && (d_q >= bin_r) && (diff_d < BAND_UNITS)) ?
				PIXEL_HIT : PIXEL_MISS;
		end
		if (state_q == S_OUT && out_free) begin
			out_pixel_q <= pixel_q;
		end
	end

`ifndef SYNTHESIS
	a_out_only_cell: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result word raised without a finished cell");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> !in_ready)
		else $error("bin memory written while accepting input");

	a_hold_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pixel)))
		else $error("result word dropped before it was taken");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/prsoi_cordic.sv =====
// Iterative vectoring CORDIC that turns a point into a bin angle, one step per cycle.
`default_nettype none
module prsoi_cordic
	import prsoi_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cordic_req_t req,
	output cordic_rsp_t rsp
);
	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_q;
	logic signed [31:0] cx_q;
	logic signed [31:0] cy_q;
	logic signed [31:0] z_q;
	logic xneg_q;
	logic xzero_q;
	logic yneg_q;
	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic [16:0] ax;
	logic [31:0] full;

	assign dx = cy_q >>> step_q;
	assign dy = cx_q >>> step_q;
	assign ax = req.x[15] ? 17'(-$signed({req.x[15], req.x})) : {1'b0, req.x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			cx_q <= $signed({15'b0, ax}) <<< CORDIC_SCALE;
			cy_q <= 32'(req.y) <<< CORDIC_SCALE;
			z_q <= '0;
			xneg_q <= req.x[15];
			xzero_q <= (req.x == '0);
			yneg_q <= req.y[15];
		end else if (busy_q) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				z_q <= z_q + $signed(atan_turn(step_q));
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				z_q <= z_q - $signed(atan_turn(step_q));
			end
		end
	end

	always_comb begin
		if (xzero_q) begin
			full = yneg_q ? 32'h0 : 32'h8000_0000;
		end else if (xneg_q) begin
			full = 32'h4000_0000 + 32'h8000_0000 - 32'(z_q);
		end else begin
			full = 32'h4000_0000 + 32'(z_q);
		end
	end

	assign rsp.done = done_q;
	assign rsp.theta = full;
endmodule
`default_nettype wire

// ===== hw/rtl/prsoi_bin_mem.sv =====
// Synchronous bin memory holding a valid flag and the nearest squared range of each bin.
`default_nettype none
module prsoi_bin_mem #(
	parameter int BINS = 360
) (
	input wire logic clk,
	input wire logic rd_en,
	input wire logic [$clog2(BINS)-1:0] rd_addr,
	output logic [32:0] rd_data,
	input wire logic wr_en,
	input wire logic [$clog2(BINS)-1:0] wr_addr,
	input wire logic [32:0] wr_data
);
	logic [32:0] mem [BINS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the polar range scan occupancy image core.
`timescale 1ns / 1ps

import prsoi_pkg::*;

class occupancy_scoreboard;
	localparam int NBINS = 360;
	localparam int ROWS = 256;
	localparam int COLS = 256;
	static int unsigned atan_tab[20] = '{
		536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087,
		667544, 333772, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304};

	logic [31:0] range_sq [NBINS];
	bit occupied [NBINS];
	logic [7:0] pixel_q [$];
	logic signed [15:0] min_h, max_h, off_x, off_y;
	logic [14:0] box_x, box_y;
	logic [11:0] cell_w, cell_h;
	int errors, pixels, kept, hits;

	function new();
		min_h = -16'sd154;
		max_h = 16'sd384;
		box_x = 0;
		box_y = 0;
		cell_w = 45;
		cell_h = 45;
		off_x = 16'sd2304;
		off_y = 0;
		foreach (occupied[i]) occupied[i] = 0;
	endfunction

	function void set_reg(reg_idx_t idx, logic [15:0] v);
		case (idx)
			REG_MIN_HEIGHT: min_h = v;
			REG_MAX_HEIGHT: max_h = v;
			REG_NEAR_BOX_X: box_x = v[14:0];
			REG_NEAR_BOX_Y: box_y = v[14:0];
			REG_CELL_WIDTH: cell_w = v[11:0];
			REG_CELL_HEIGHT: cell_h = v[11:0];
			REG_GRID_OFFSET_X: off_x = v;
			REG_GRID_OFFSET_Y: off_y = v;
		endcase
	endfunction

	function int sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return int'(v);
	endfunction

	function int centre_x(int row);
		return sat16((longint'(ROWS / 2) - row) * longint'(cell_h) + longint'(off_x));
	endfunction

	function int centre_y(int col);
		return sat16((longint'(COLS / 2) - col) * longint'(cell_w) + longint'(off_y));
	endfunction

	function int unsigned bin_of(int x, int y);
		longint cx, cy, z, t, dx, dy, full;
		logic [31:0] theta;
		longint unsigned idx;
		if (x == 0) begin
			theta = (y >= 0) ? 32'h8000_0000 : 32'h0;
		end else begin
			cx = longint'(x < 0 ? -x : x) * 16384;
			cy = longint'(y) * 16384;
			z = 0;
			for (int i = 0; i < 20; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy > 0) begin
					t = cx + dx;
					cy = cy - dy;
					z += atan_tab[i];
				end else begin
					t = cx - dx;
					cy = cy + dy;
					z -= atan_tab[i];
				end
				cx = t;
			end
			if (x > 0)
				full = (longint'(1) << 30) + z;
			else
				full = (longint'(1) << 30) + (longint'(1) << 31) - z;
			theta = full[31:0];
		end
		idx = ({32'b0, theta} * NBINS + 64'h8000_0000) >> 32;
		if (idx >= NBINS)
			idx = 0;
		return int'(idx);
	endfunction

	function logic [31:0] dist_sq(int x, int y);
		longint s;
		s = longint'(x) * x + longint'(y) * y;
		return s[31:0];
	endfunction

	function void note_input(op_t o, int x, int y, int z, int row, int col);
		int b;
		logic [31:0] d;
		logic [7:0] p;
		case (o)
			OP_CLEAR: foreach (occupied[i]) occupied[i] = 0;
			OP_POINT: begin
				if (z < min_h || z > max_h)
					return;
				if ((x < 0 ? -x : x) < box_x && (y < 0 ? -y : y) < box_y)
					return;
				b = bin_of(x, y);
				d = dist_sq(x, y);
				kept++;
				if (!occupied[b] || d < range_sq[b]) begin
					range_sq[b] = d;
					occupied[b] = 1;
				end
			end
			OP_CELL: begin
				p = PIXEL_MISS;
				if (row < ROWS && col < COLS) begin
					b = bin_of(centre_x(row), centre_y(col));
					d = dist_sq(centre_x(row), centre_y(col));
					if (occupied[b] && d >= range_sq[b] && (d - range_sq[b]) < BAND_UNITS)
						p = PIXEL_HIT;
				end
				pixel_q.push_back(p);
			end
			default: ;
		endcase
	endfunction

	function void check_pixel(logic [7:0] got);
		logic [7:0] want;
		if (pixel_q.size() == 0) begin
			$error("pixel: no word expected, got %0d", got);
			errors++;
			return;
		end
		want = pixel_q.pop_front();
		pixels++;
		if (want == PIXEL_HIT)
			hits++;
		if (got !== want) begin
			$error("pixel: expected %0d, got %0d", want, got);
			errors++;
		end
	endfunction
endclass

module testbench;
	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_wdata;
	logic in_valid, in_ready;
	logic [1:0] op;
	logic signed [15:0] point_x, point_y, point_z;
	logic [7:0] cell_row, cell_col;
	logic out_valid, out_ready;
	logic [7:0] pixel;

	occupancy_scoreboard sb;
	bit calm;
	bit hold_req;
	int sent;
	int rows_pick [$];
	int cols_pick [$];

	polar_range_scan_occupancy_image_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .point_x(point_x), .point_y(point_y), .point_z(point_z),
		.cell_row(cell_row), .cell_col(cell_col),
		.out_valid(out_valid), .out_ready(out_ready), .pixel(pixel)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pixel(pixel);
	end

	initial begin
		out_ready = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
				out_ready <= 1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1;
			end else begin
				out_ready <= 1;
			end
			@(posedge clk);
		end
	end

	task automatic send_word(op_t o, int x, int y, int z, int row, int col);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		point_x <= x[15:0];
		point_y <= y[15:0];
		point_z <= z[15:0];
		cell_row <= row[7:0];
		cell_col <= col[7:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(o, int'($signed(x[15:0])), int'($signed(y[15:0])),
			int'($signed(z[15:0])), row & 8'hff, col & 8'hff);
		sent++;
	endtask

	task automatic write_reg(reg_idx_t idx, int v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v[15:0];
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, v[15:0]);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pixel_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_all(int mn, int mx, int bx, int by, int cw, int ch, int ox, int oy);
		drain();
		write_reg(REG_MIN_HEIGHT, mn);
		write_reg(REG_MAX_HEIGHT, mx);
		write_reg(REG_NEAR_BOX_X, bx);
		write_reg(REG_NEAR_BOX_Y, by);
		write_reg(REG_CELL_WIDTH, cw);
		write_reg(REG_CELL_HEIGHT, ch);
		write_reg(REG_GRID_OFFSET_X, ox);
		write_reg(REG_GRID_OFFSET_Y, oy);
	endtask

	function automatic int band_z();
		if (sb.min_h > sb.max_h)
			return $urandom_range(0, 65535);
		return $urandom_range(int'(sb.max_h) + 32768, int'(sb.min_h) + 32768) - 32768;
	endfunction

	// One frame: clear, points placed on chosen cell centres plus stray points,
	// then classification of those cells, their neighbors and random cells.
	task automatic run_frame(int npts, int ncells);
		int r, c, k;
		send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
		rows_pick.delete();
		cols_pick.delete();
		for (int i = 0; i < 6; i++) begin
			rows_pick.push_back($urandom_range(0, 255));
			cols_pick.push_back($urandom_range(0, 255));
		end
		for (int i = 0; i < npts; i++) begin
			k = $urandom_range(0, 5);
			case ($urandom_range(0, 9))
				0: send_word(op_t'($urandom_range(0, 3) == 0 ? OP_NONE : OP_POINT),
					$urandom, $urandom, $urandom, $urandom, $urandom);
				1, 2: send_word(OP_POINT, $urandom, $urandom, band_z(), $urandom, $urandom);
				default: send_word(OP_POINT, sb.centre_x(rows_pick[k] + $urandom_range(0, 1)),
					sb.centre_y(cols_pick[k]), band_z(), $urandom, $urandom);
			endcase
		end
		for (int i = 0; i < ncells; i++) begin
			k = $urandom_range(0, 5);
			r = rows_pick[k];
			c = cols_pick[k];
			if ($urandom_range(0, 3) == 0) begin
				r = $urandom_range(0, 255);
				c = $urandom_range(0, 255);
			end else if ($urandom_range(0, 1) == 0) begin
				r = (r + $urandom_range(0, 4)) & 8'hff;
				c = (c + $urandom_range(0, 2)) & 8'hff;
			end
			send_word(OP_CELL, $urandom, $urandom, $urandom, r, c);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_wdata = 0;
		in_valid = 0;
		op = 0;
		point_x = 0;
		point_y = 0;
		point_z = 0;
		cell_row = 0;
		cell_col = 0;
		calm = 0;
		hold_req = 0;
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		send_word(OP_CLEAR, 0, 0, 0, 0, 0);
		send_word(OP_CELL, 0, 0, 0, 128, 128);
		send_word(OP_POINT, 0, 100, 0, 0, 0);
		send_word(OP_POINT, 0, -100, 0, 0, 0);
		send_word(OP_POINT, 0, 0, 0, 0, 0);
		send_word(OP_POINT, -32768, -32768, 0, 0, 0);
		send_word(OP_POINT, 32767, 32767, 384, 0, 0);
		send_word(OP_POINT, -32768, 1, -154, 0, 0);
		send_word(OP_POINT, 100, 0, 385, 0, 0);
		send_word(OP_POINT, 100, 0, -155, 0, 0);
		send_word(OP_POINT, 32767, -32768, -32768, 0, 0);
		send_word(OP_POINT, 2304, 0, 0, 0, 0);
		send_word(OP_POINT, 2304, 0, 0, 0, 0);
		send_word(OP_POINT, 2350, 0, 0, 0, 0);
		send_word(OP_NONE, 1000, 1000, 0, 5, 5);
		send_word(OP_CELL, 0, 0, 0, 128, 128);
		send_word(OP_CELL, 0, 0, 0, 127, 128);
		send_word(OP_CELL, 0, 0, 0, 0, 0);
		send_word(OP_CELL, 0, 0, 0, 255, 255);
		send_word(OP_CELL, 0, 0, 0, 0, 255);
		send_word(OP_CELL, 0, 0, 0, 255, 0);
		while (sent < 200) run_frame(18, 14);

		set_all(-32768, 32767, 0, 0, 1, 1, 0, 0);
		send_word(OP_CLEAR, 0, 0, 0, 0, 0);
		send_word(OP_POINT, 10, 0, 32767, 0, 0);
		hold_req = 1;
		for (int i = 0; i < 30; i++)
			send_word(OP_CELL, 0, 0, 0, $urandom_range(100, 140), 128);
		while (sent < 360) run_frame(18, 14);

		set_all(100, -100, 32767, 32767, 4095, 4095, 32767, -32768);
		while (sent < 430) run_frame(10, 14);

		set_all(-32768, 32767, $urandom_range(0, 2000), $urandom_range(0, 2000), 0, 0,
			$urandom, $urandom);
		while (sent < 500) run_frame(12, 10);

		set_all($urandom_range(0, 400) - 400, $urandom_range(0, 800), $urandom_range(0, 300),
			$urandom_range(0, 300), $urandom_range(1, 300), $urandom_range(1, 300),
			$urandom, $urandom);
		while (sent < 700) run_frame(18, 14);
		drain();
		for (int i = 0; i < 20; i++)
			send_word(OP_CELL, 0, 0, 0, $urandom, $urandom);

		set_all(-154, 384, 200, 200, 45, 45, 2304, 0);
		while (sent < 900) run_frame(18, 14);
		calm = 1;
		while (sent < 1050) run_frame(18, 14);
		drain();

		$display("Sent %0d words across six register settings; %0d points kept.",
			sent, sb.kept);
		$display("Checked %0d pixels, %0d of them boundary hits.", sb.pixels, sb.hits);
		if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			if (sb.pixel_q.size() != 0)
				$error("pixel: %0d expected words never arrived", sb.pixel_q.size());
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/prsoi_pkg.sv
hw/rtl/prsoi_cordic.sv
hw/rtl/prsoi_bin_mem.sv
hw/rtl/polar_range_scan_occupancy_image_core.sv
test/testbench.sv
